/* hdl/tcpu_pkg.sv */
// Shared types, constants and helpers for the toy CPU instruction execute block.
// Used by every module under hdl/; depends on nothing.
package tcpu_pkg;

    localparam int NUM_REGS   = 5;
    localparam int PTR_BITS   = 8;
    localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 4;
    localparam int SEL_W      = 3;
    localparam int IMM_W      = 8;
    localparam int NEXT_PTR_W = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CMD_W-1:0] OP_HALT    = 4'd0;
    localparam logic [CMD_W-1:0] OP_LOADIMM = 4'd1;
    localparam logic [CMD_W-1:0] OP_ADD     = 4'd2;
    localparam logic [CMD_W-1:0] OP_ADDIMM  = 4'd3;
    localparam logic [CMD_W-1:0] OP_AND     = 4'd4;
    localparam logic [CMD_W-1:0] OP_OR      = 4'd5;
    localparam logic [CMD_W-1:0] OP_XOR     = 4'd6;
    localparam logic [CMD_W-1:0] OP_JUMP    = 4'd7;
    localparam logic [CMD_W-1:0] OP_BEQ     = 4'd8;
    localparam logic [CMD_W-1:0] OP_MOVE    = 4'd9;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_reg_wr;

    typedef struct packed {
        t_reg_wr              wr;
        logic [PTR_BITS-1:0]  next_ptr;
        logic                 halted;
        logic                 taken;
        logic [DATA_W-1:0]    dst_value;
    } t_exec_res;

    function automatic logic reg_in_range(input logic [SEL_W-1:0] sel);
        return (int'(sel) < NUM_REGS);
    endfunction

    function automatic logic [REG_IDX_W-1:0] reg_addr(input logic [SEL_W-1:0] sel);
        return REG_IDX_W'(sel);
    endfunction

endpackage

/* hdl/tcpu_regfile.sv */
// Register file: memory array with per-entry valid bits and registered reads.
// Depends on tcpu_pkg; a write in the same cycle as a read is forwarded.
module tcpu_regfile
    import tcpu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SEL_W-1:0]  i_rd_a_sel,
    input  logic [SEL_W-1:0]  i_rd_b_sel,
    input  t_reg_wr           i_wr,
    output logic [DATA_W-1:0] o_rd_a,
    output logic [DATA_W-1:0] o_rd_b
);

    logic [DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Out-of-range selects and never-written entries read as zero.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (!reg_in_range(i_rd_a_sel)) begin
                r_rd_a <= '0;
            end else if (i_wr.en && i_wr.addr == reg_addr(i_rd_a_sel)) begin
                r_rd_a <= i_wr.data;
            end else if (r_valid[reg_addr(i_rd_a_sel)]) begin
                r_rd_a <= r_mem[reg_addr(i_rd_a_sel)];
            end else begin
                r_rd_a <= '0;
            end

            if (!reg_in_range(i_rd_b_sel)) begin
                r_rd_b <= '0;
            end else if (i_wr.en && i_wr.addr == reg_addr(i_rd_b_sel)) begin
                r_rd_b <= i_wr.data;
            end else if (r_valid[reg_addr(i_rd_b_sel)]) begin
                r_rd_b <= r_mem[reg_addr(i_rd_b_sel)];
            end else begin
                r_rd_b <= '0;
            end
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

/* hdl/tcpu_alu.sv */
// Execute logic: decodes one instruction, computes the register write,
// the next pointer and the status flags. Depends on tcpu_pkg.
module tcpu_alu
    import tcpu_pkg::*;
(
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SEL_W-1:0]    i_dst_sel,
    input  logic [IMM_W-1:0]    i_imm,
    input  logic [DATA_W-1:0]   i_a,
    input  logic [DATA_W-1:0]   i_b,
    input  logic [PTR_BITS-1:0] i_ptr,
    output t_exec_res           o_res
);

    logic [DATA_W-1:0]   imm_sx;
    logic [PTR_BITS-1:0] imm_ptr;
    logic [PTR_BITS-1:0] ptr_inc;
    logic                wr_req;
    logic [DATA_W-1:0]   wr_data;

    assign imm_sx  = DATA_W'(signed'(i_imm));
    assign imm_ptr = PTR_BITS'(i_imm);
    assign ptr_inc = PTR_BITS'(i_ptr + 1'b1);

    always_comb begin
        wr_req         = 1'b0;
        wr_data        = i_a;
        o_res.next_ptr = ptr_inc;
        o_res.halted   = 1'b0;
        o_res.taken    = 1'b0;
        case (i_cmd)
            OP_HALT: begin
                o_res.halted   = 1'b1;
                o_res.next_ptr = i_ptr;
            end
            OP_LOADIMM: begin
                wr_req  = 1'b1;
                wr_data = imm_sx;
            end
            OP_ADD: begin
                wr_req  = 1'b1;
                wr_data = i_a + i_b;
            end
            OP_ADDIMM: begin
                wr_req  = 1'b1;
                wr_data = i_a + imm_sx;
            end
            OP_AND: begin
                wr_req  = 1'b1;
                wr_data = i_a & i_b;
            end
            OP_OR: begin
                wr_req  = 1'b1;
                wr_data = i_a | i_b;
            end
            OP_XOR: begin
                wr_req  = 1'b1;
                wr_data = i_a ^ i_b;
            end
            OP_JUMP: begin
                o_res.next_ptr = imm_ptr;
                o_res.taken    = 1'b1;
            end
            OP_BEQ: begin
                if (i_a == i_b) begin
                    o_res.next_ptr = imm_ptr;
                    o_res.taken    = 1'b1;
                end
            end
            OP_MOVE: begin
                wr_req  = 1'b1;
                wr_data = i_a;
            end
            default: begin
            end
        endcase

        // Drop writes to registers that do not exist.
        o_res.wr.en     = wr_req && reg_in_range(i_dst_sel);
        o_res.wr.addr   = reg_addr(i_dst_sel);
        o_res.wr.data   = wr_data;
        o_res.dst_value = o_res.wr.en ? wr_data : i_b;
    end

endmodule

/* hdl/toy_cpu_instruction_execute.sv */
// Toy CPU instruction execute block, top level.
// The input stage registers the instruction and the register file read; the output
// register holds the result. One instruction per cycle when the output is not stalled.
// Reset (i_rst_n low, synchronous): pipeline empties, pointer and all registers read zero.
// Depends on tcpu_pkg, tcpu_regfile and tcpu_alu.
module toy_cpu_instruction_execute
    import tcpu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [3:0] cmd, [6:4] src_reg, [9:7] dst_reg, [17:10] imm, [23:18] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] next_pointer, [39:8] dst_value
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] halted, [1] branch_taken
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    logic                  accept;
    logic                  advance;
    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_cmd;
    logic [SEL_W-1:0]      r_dst_sel;
    logic [IMM_W-1:0]      r_imm;
    logic [PTR_BITS-1:0]   r_ptr;
    logic [DATA_W-1:0]     rd_a;
    logic [DATA_W-1:0]     rd_b;
    t_exec_res             res;
    t_reg_wr               wr;
    logic                  r_out_valid;
    logic [NEXT_PTR_W-1:0] r_next_pointer;
    logic                  r_halted;
    logic                  r_taken;
    logic [DATA_W-1:0]     r_dst_value;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_s_axis_tdata[3:0];
            r_dst_sel <= i_s_axis_tdata[9:7];
            r_imm     <= i_s_axis_tdata[17:10];
        end
    end

    assign wr.en   = res.wr.en && advance;
    assign wr.addr = res.wr.addr;
    assign wr.data = res.wr.data;

    tcpu_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_a_sel (i_s_axis_tdata[6:4]),
        .i_rd_b_sel (i_s_axis_tdata[9:7]),
        .i_wr       (wr),
        .o_rd_a     (rd_a),
        .o_rd_b     (rd_b)
    );

    tcpu_alu u_alu (
        .i_cmd     (r_cmd),
        .i_dst_sel (r_dst_sel),
        .i_imm     (r_imm),
        .i_a       (rd_a),
        .i_b       (rd_b),
        .i_ptr     (r_ptr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (advance) begin
            r_ptr <= res.next_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_next_pointer <= NEXT_PTR_W'(res.next_ptr);
            r_halted       <= res.halted;
            r_taken        <= res.taken;
            r_dst_value    <= res.dst_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_dst_value, r_next_pointer};
    assign o_m_axis_tuser  = {r_taken, r_halted};

endmodule

/* hdl/tcpu_checker.sv */
// Port-level checks for toy_cpu_instruction_execute, attached by bind.
// Depends on tcpu_pkg.
module tcpu_checker
    import tcpu_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    logic                  out_xfer;
    logic [NEXT_PTR_W-1:0] r_last_ptr;

    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // Track the pointer of the last delivered result; it starts at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ptr <= '0;
        end else if (out_xfer) begin
            r_last_ptr <= o_m_axis_tdata[7:0];
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with no result waiting");

    a_halt_no_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("halt reported together with a taken branch");

    a_halt_keeps_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == r_last_ptr)
        else $error("halt moved the pointer");

endmodule

bind toy_cpu_instruction_execute tcpu_checker u_tcpu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* bench/tb_toy_cpu_instruction_execute.sv */
// Self-checking bench for toy_cpu_instruction_execute: streams instructions into the core,
// predicts every result with a behavioral copy of the register file and pointer, and
// compares each output transaction field by field. Depends on tcpu_pkg and the RTL.
module tb_toy_cpu_instruction_execute;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpu_pkg::*;

    localparam int N_DIRECTED  = 23;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_LEN    = 150;
    localparam int DRAIN_WAIT  = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTED = 40;

    // opcodes without a function in the core
    localparam logic [CMD_W-1:0] OP_NOP_FIRST = 4'd10;
    localparam logic [CMD_W-1:0] OP_NOP_MID   = 4'd13;
    localparam logic [CMD_W-1:0] OP_NOP_LAST  = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEL_W-1:0] src_reg;
        logic [SEL_W-1:0] dst_reg;
        logic [IMM_W-1:0] imm;
    } t_instr;

    typedef struct packed {
        logic [NEXT_PTR_W-1:0] next_pointer;
        logic                  halted;
        logic                  branch_taken;
        logic [DATA_W-1:0]     dst_value;
    } t_exec_result;

    typedef struct packed {
        t_instr       ins;
        logic         fixed;
        t_exec_result want;
    } t_instr_row;

    // row without a typed-in result: the predictor supplies it
    localparam logic [$bits(t_exec_result):0] PRED = '0;

    // cmd, src, dst, imm, then either PRED or {1, next_pointer, halted, taken, dst_value}
    t_instr_row directed_rows [N_DIRECTED] = '{
        {OP_HALT,      3'd0, 3'd0, 8'h00, 1'b1, 8'd0,   1'b1, 1'b0, 32'h0000_0000},
        {OP_LOADIMM,   3'd0, 3'd1, 8'h7f, 1'b1, 8'd1,   1'b0, 1'b0, 32'h0000_007f},
        {OP_LOADIMM,   3'd0, 3'd2, 8'h80, 1'b1, 8'd2,   1'b0, 1'b0, 32'hffff_ff80},
        {OP_ADD,       3'd1, 3'd2, 8'h00, 1'b1, 8'd3,   1'b0, 1'b0, 32'hffff_ffff},
        {OP_ADDIMM,    3'd2, 3'd3, 8'h01, 1'b1, 8'd4,   1'b0, 1'b0, 32'h0000_0000},
        {OP_AND,       3'd1, 3'd2, 8'h00, PRED},
        {OP_OR,        3'd2, 3'd4, 8'h00, PRED},
        {OP_XOR,       3'd4, 3'd1, 8'h00, PRED},
        {OP_MOVE,      3'd2, 3'd0, 8'h00, PRED},
        // jump to -1 lands on the top pointer value
        {OP_JUMP,      3'd0, 3'd3, 8'hff, 1'b1, 8'd255, 1'b0, 1'b1, 32'h0000_0000},
        {OP_ADDIMM,    3'd3, 3'd3, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 32'h0000_0000},
        {OP_BEQ,       3'd3, 3'd1, 8'h64, 1'b1, 8'd100, 1'b0, 1'b1, 32'h0000_0000},
        {OP_BEQ,       3'd0, 3'd1, 8'h32, PRED},
        // indexes past the register file
        {OP_LOADIMM,   3'd0, 3'd5, 8'h05, PRED},
        {OP_MOVE,      3'd7, 3'd2, 8'h00, PRED},
        {OP_ADD,       3'd6, 3'd7, 8'h00, PRED},
        {OP_BEQ,       3'd5, 3'd6, 8'h80, PRED},
        {OP_NOP_FIRST, 3'd1, 3'd4, 8'hff, PRED},
        {OP_NOP_MID,   3'd4, 3'd4, 8'h55, PRED},
        {OP_NOP_LAST,  3'd7, 3'd7, 8'haa, PRED},
        {OP_HALT,      3'd1, 3'd0, 8'h7f, PRED},
        {OP_ADDIMM,    3'd0, 3'd4, 8'hff, PRED},
        {OP_JUMP,      3'd2, 3'd1, 8'h7f, PRED}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [OUT_TUSER_W-1:0] m_user;

    // behavioral copy of the core state
    logic [DATA_W-1:0]   gpr [NUM_REGS];
    logic [PTR_BITS-1:0] ip;

    t_instr_row   instr_q [$];
    t_exec_result result_q [$];
    t_instr_row   cur_row;

    int n_queued;
    int n_instr_taken;
    int n_results;
    int n_errors;
    int quiet_cycles;
    int s_idle_pct;
    int m_idle_pct;
    int hold_left;
    bit hold_done;

    toy_cpu_instruction_execute dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] gpr_read(input logic [SEL_W-1:0] sel);
        return (int'(sel) < NUM_REGS) ? gpr[sel] : '0;
    endfunction

    // run one instruction on the state copy and return what the core should report
    function automatic t_exec_result exec_instr(input t_instr ins);
        t_exec_result        res;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic [DATA_W-1:0]   imm_ext;
        logic [DATA_W-1:0]   wr_val;
        logic                wr_en;
        logic [PTR_BITS-1:0] nxt;
        a       = gpr_read(ins.src_reg);
        b       = gpr_read(ins.dst_reg);
        imm_ext = {{(DATA_W-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
        nxt     = ip + 1'b1;
        wr_en   = 1'b1;
        wr_val  = '0;
        res     = '0;
        case (ins.cmd)
            OP_HALT: begin
                wr_en      = 1'b0;
                res.halted = 1'b1;
                nxt        = ip;
            end
            OP_LOADIMM: wr_val = imm_ext;
            OP_ADD:     wr_val = a + b;
            OP_ADDIMM:  wr_val = a + imm_ext;
            OP_AND:     wr_val = a & b;
            OP_OR:      wr_val = a | b;
            OP_XOR:     wr_val = a ^ b;
            OP_JUMP: begin
                wr_en            = 1'b0;
                nxt              = PTR_BITS'(ins.imm);
                res.branch_taken = 1'b1;
            end
            OP_BEQ: begin
                wr_en = 1'b0;
                if (a == b) begin
                    nxt              = PTR_BITS'(ins.imm);
                    res.branch_taken = 1'b1;
                end
            end
            OP_MOVE:    wr_val = a;
            default:    wr_en = 1'b0;
        endcase
        if (wr_en && int'(ins.dst_reg) < NUM_REGS)
            gpr[ins.dst_reg] = wr_val;
        ip = nxt;
        res.next_pointer = NEXT_PTR_W'(ip);
        res.dst_value    = gpr_read(ins.dst_reg);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("[%0t] result %0d: %s got %h want %h", $realtime, n_results, what,
                     got, want);
    endtask

    task automatic queue_random(input int count);
        t_instr_row row;
        repeat (count) begin
            row             = '0;
            row.ins.cmd     = CMD_W'($urandom_range(int'(OP_NOP_MID)));
            row.ins.src_reg = SEL_W'($urandom_range(NUM_REGS - 1));
            row.ins.dst_reg = SEL_W'($urandom_range(NUM_REGS - 1));
            row.ins.imm     = IMM_W'($urandom_range(255));
            // make equal-operand branches common
            if (row.ins.cmd == OP_BEQ && $urandom_range(1) == 1)
                row.ins.dst_reg = row.ins.src_reg;
            instr_q.push_back(row);
            n_queued++;
        end
    endtask

    // input side: predict on each accepted transaction, then offer the next instruction
    always @(posedge clk) begin
        t_exec_result pred;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // advance the state copy on every row, typed-in or not
                pred = exec_instr(cur_row.ins);
                result_q.push_back(cur_row.fixed ? cur_row.want : pred);
                n_instr_taken++;
            end
            if (!s_valid || s_ready) begin
                if (instr_q.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                    cur_row = instr_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= IN_TDATA_W'({cur_row.ins.imm, cur_row.ins.dst_reg,
                                            cur_row.ins.src_reg, cur_row.ins.cmd});
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output side ready: random stalls plus one long hold-off to back the core up
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (!hold_done && n_instr_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_exec_result want;
        if (rst_n && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_data[NEXT_PTR_W +: DATA_W],
                                '0);
            end else begin
                want = result_q.pop_front();
                if (m_data[NEXT_PTR_W-1:0] !== want.next_pointer)
                    report_mismatch("next_pointer", DATA_W'(m_data[NEXT_PTR_W-1:0]),
                                    DATA_W'(want.next_pointer));
                if (m_user[0] !== want.halted)
                    report_mismatch("halted", DATA_W'(m_user[0]), DATA_W'(want.halted));
                if (m_user[1] !== want.branch_taken)
                    report_mismatch("branch_taken", DATA_W'(m_user[1]),
                                    DATA_W'(want.branch_taken));
                if (m_data[NEXT_PTR_W +: DATA_W] !== want.dst_value)
                    report_mismatch("dst_value", m_data[NEXT_PTR_W +: DATA_W], want.dst_value);
            end
            n_results++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        foreach (gpr[k])
            gpr[k] = '0;
        ip         = '0;
        s_idle_pct = 38;
        m_idle_pct = 55;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            instr_q.push_back(directed_rows[k]);
            n_queued++;
        end
        queue_random(280);
        wait (n_instr_taken == n_queued);

        s_idle_pct = 55;
        m_idle_pct = 38;
        queue_random(300);
        wait (n_instr_taken == n_queued);

        // no idling: the hold-off lands in this stretch
        s_idle_pct = 0;
        m_idle_pct = 0;
        queue_random(300);
        wait (n_instr_taken == n_queued);

        wait (result_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
